// ===== hdl/bffa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bffa_pkg
// Shared types, codes and helpers of the first-fit bitmap allocator.
// ----------------------------------------------------------------------------
package bffa_pkg;

    // Default bitmap size in entries.
    localparam int DEF_MAX_ENTRIES = 8192;

    // Width of one bitmap memory word and of entry numbers.
    localparam int WORD_W   = 32;
    localparam int NUMBER_W = 32;

    // Payload widths of the stream ports.
    localparam int COUNT_W    = 14;
    localparam int STATUS_W   = 2;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 48;

    // Configuration port.
    localparam int CFG_DATA_W = 16;
    localparam int ENTRIES_W  = 14;
    localparam int GROUP_W    = 16;
    localparam logic CFG_ENTRIES = 1'b0;
    localparam logic CFG_GROUP   = 1'b1;

    // Request kinds.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_ALLOCATED = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NONE_FREE = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FREED     = 2'd2;

    // Position of the lowest clear bit of a word (0 when the word is all ones).
    function automatic logic [4:0] first_zero(input logic [WORD_W-1:0] w);
        logic [4:0] pos;
        pos = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (!w[i])
            begin
                pos = 5'(i);
            end
        end
        return pos;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/bitmap_first_free_allocator.sv =====
`default_nettype none
// Allocate: the bitmap memory read port scans one 32-bit word per cycle
//   from word 0.
// Free: the bit to clear comes from the 32-step bit-serial remainder unit.
// One request at a time; the next request is taken while a result waits.
// After reset a clearing pass writes zeros over MAX_ENTRIES/32 words (256 by
//   default) with s_tready low; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
// bitmap_first_free_allocator
// First-fit allocator over a one-bit-per-entry usage bitmap held in a
// synchronous memory, with a saturating free-entry counter.
// ----------------------------------------------------------------------------
module bitmap_first_free_allocator
    import bffa_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Request stream.
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // [31:0] entry_number
    input  wire logic [0:0]            s_tuser,   // [0] opcode
    // Result stream.
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,   // [31:0] allocated_number, [45:32] free_count
    output logic [STATUS_W-1:0]        m_tuser,   // [1:0] status
    // Configuration writes.
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic                  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int WORDS  = (MAX_ENTRIES + WORD_W - 1) / WORD_W;
    localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BIT_W  = ADDR_W + 5;
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int PROD_W = GROUP_W + CNT_W;

    typedef enum logic [4:0]
    {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_SCAN   = 5'b00100,
        S_DIVIDE = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    state_t               state_reg;
    logic [ENTRIES_W-1:0] entries_reg;
    logic [GROUP_W-1:0]   group_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic [CNT_W-1:0]     e_reg;
    logic [ADDR_W-1:0]    last_word_reg;
    logic [WORD_W-1:0]    inv_mask_reg;
    logic [NUMBER_W-1:0]  prod_reg;
    logic                 op_reg;
    logic [ADDR_W-1:0]    clr_addr_reg;
    logic [ADDR_W-1:0]    scan_addr_reg;
    logic                 issuing_reg;
    logic                 chk_valid_reg;
    logic [ADDR_W-1:0]    chk_addr_reg;
    logic                 found_reg;
    logic [ADDR_W-1:0]    tgt_addr_reg;
    logic [4:0]           tgt_bit_reg;
    logic [WORD_W-1:0]    word_reg;
    logic [WORD_W-1:0]    rd_data_reg;
    logic                 m_tvalid_reg;
    logic [NUMBER_W-1:0]  out_number_reg;
    logic [STATUS_W-1:0]  out_status_reg;
    logic [COUNT_W-1:0]   out_count_reg;

    logic [WORD_W-1:0]    bitmap_mem [WORDS];

    logic [CNT_W-1:0]     e_eff;
    logic [CNT_W-1:0]     e_m1;
    logic [BIT_W-1:0]     e_m1_bits;
    logic [PROD_W-1:0]    prod_full;
    logic                 in_accept;
    logic                 out_free;
    logic                 finish_fire;
    logic [WORD_W-1:0]    masked_word;
    logic                 scan_hit;
    logic                 scan_end;
    logic [4:0]           hit_bit;
    logic                 div_start;
    logic                 div_done;
    logic [CNT_W-1:0]     div_rem;
    logic [BIT_W-1:0]     rem_bits;
    logic [WORD_W-1:0]    word_cur;
    logic [WORD_W-1:0]    bit_sel;
    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [WORD_W-1:0]    wr_data;
    logic [NUMBER_W-1:0]  number_next;
    logic [STATUS_W-1:0]  status_next;

    // Effective entry count: zero acts as one, clipped to the bitmap size.
    always_comb
    begin
        if (entries_reg == '0)
        begin
            e_eff = CNT_W'(1);
        end
        else if (32'(entries_reg) > 32'(MAX_ENTRIES))
        begin
            e_eff = CNT_W'(MAX_ENTRIES);
        end
        else
        begin
            e_eff = CNT_W'(entries_reg);
        end
        e_m1      = e_eff - 1'b1;
        e_m1_bits = BIT_W'(e_m1);
        prod_full = group_reg * e_eff;
    end

    // Handshakes.
    assign s_tready    = (state_reg == S_IDLE);
    assign in_accept   = s_tvalid && s_tready;
    assign out_free    = !m_tvalid_reg || m_tready;
    assign finish_fire = (state_reg == S_FINISH) && out_free;
    assign cfg_ready   = 1'b1;

    // Scan evaluation of the word read in the previous cycle.
    always_comb
    begin
        masked_word = rd_data_reg;
        if (chk_addr_reg == last_word_reg)
        begin
            masked_word = rd_data_reg | inv_mask_reg;
        end
        scan_hit = chk_valid_reg && (masked_word != '1);
        scan_end = chk_valid_reg && (chk_addr_reg == last_word_reg);
        hit_bit  = first_zero(masked_word);
    end

    // Remainder unit for the index of a freed entry.
    assign div_start = in_accept && (s_tuser[0] == OP_FREE);

    bffa_rem_unit #(
        .DIVISOR_W (CNT_W)
    ) u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (s_tdata[NUMBER_W-1:0] - 32'd1),
        .divisor   (e_eff),
        .done      (div_done),
        .remainder (div_rem)
    );

    assign rem_bits = BIT_W'(div_rem);

    // Memory port control.
    always_comb
    begin
        word_cur = (op_reg == OP_FREE) ? rd_data_reg : word_reg;
        bit_sel  = WORD_W'(1) << tgt_bit_reg;
        rd_en    = ((state_reg == S_SCAN) && issuing_reg) ||
                   ((state_reg == S_DIVIDE) && div_done);
        rd_addr  = (state_reg == S_SCAN) ? scan_addr_reg : rem_bits[BIT_W-1:5];
        wr_en    = (state_reg == S_CLEAR) ||
                   (finish_fire && ((op_reg == OP_FREE) || found_reg));
        wr_addr  = (state_reg == S_CLEAR) ? clr_addr_reg : tgt_addr_reg;
        if (state_reg == S_CLEAR)
        begin
            wr_data = '0;
        end
        else if (op_reg == OP_FREE)
        begin
            wr_data = word_cur & ~bit_sel;
        end
        else
        begin
            wr_data = word_cur | bit_sel;
        end
    end

    // Bitmap memory, registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bitmap_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= bitmap_mem[rd_addr];
        end
    end

    // Result of the request being finished.
    always_comb
    begin
        cnt_next    = cnt_reg;
        number_next = '0;
        if (op_reg == OP_FREE)
        begin
            status_next = STAT_FREED;
            if (cnt_reg < e_reg)
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
        else if (found_reg)
        begin
            status_next = STAT_ALLOCATED;
            number_next = 32'({tgt_addr_reg, tgt_bit_reg}) + 32'd1 + prod_reg;
            if (cnt_reg != '0)
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
        else
        begin
            status_next = STAT_NONE_FREE;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg <= ENTRIES_W'(8192);
            group_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ENTRIES: entries_reg <= cfg_data[ENTRIES_W-1:0];
                CFG_GROUP:   group_reg   <= cfg_data[GROUP_W-1:0];
            endcase
        end
    end

    // Sequencer: clearing pass, word scan, remainder wait, write back.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            cnt_reg       <= CNT_W'(MAX_ENTRIES);
            issuing_reg   <= 1'b0;
            chk_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            chk_valid_reg <= 1'b0;

            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == ADDR_W'(WORDS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end

                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        issuing_reg <= 1'b1;
                        state_reg   <= (s_tuser[0] == OP_FREE) ? S_DIVIDE : S_SCAN;
                    end
                end

                S_SCAN:
                begin
                    // Issue the next word while checking the previous one.
                    if (issuing_reg)
                    begin
                        chk_valid_reg <= 1'b1;
                        if (scan_addr_reg == last_word_reg)
                        begin
                            issuing_reg <= 1'b0;
                        end
                    end
                    if (scan_hit || scan_end)
                    begin
                        chk_valid_reg <= 1'b0;
                        issuing_reg   <= 1'b0;
                        state_reg     <= S_FINISH;
                    end
                end

                S_DIVIDE:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_FINISH;
                    end
                end

                S_FINISH:
                begin
                    if (out_free)
                    begin
                        cnt_reg      <= cnt_next;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Per-request datapath registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg        <= s_tuser[0];
            e_reg         <= e_eff;
            last_word_reg <= e_m1_bits[BIT_W-1:5];
            inv_mask_reg  <= ~({WORD_W{1'b1}} >> (5'd31 - e_m1_bits[4:0]));
            prod_reg      <= NUMBER_W'(prod_full);
            scan_addr_reg <= '0;
            found_reg     <= 1'b0;
        end
        if ((state_reg == S_SCAN) && issuing_reg)
        begin
            chk_addr_reg <= scan_addr_reg;
            if (scan_addr_reg != last_word_reg)
            begin
                scan_addr_reg <= scan_addr_reg + 1'b1;
            end
        end
        if ((state_reg == S_SCAN) && scan_hit)
        begin
            found_reg    <= 1'b1;
            tgt_addr_reg <= chk_addr_reg;
            tgt_bit_reg  <= hit_bit;
            word_reg     <= rd_data_reg;
        end
        if ((state_reg == S_DIVIDE) && div_done)
        begin
            tgt_addr_reg <= rem_bits[BIT_W-1:5];
            tgt_bit_reg  <= rem_bits[4:0];
        end
        if (finish_fire)
        begin
            out_number_reg <= number_next;
            out_status_reg <= status_next;
            out_count_reg  <= COUNT_W'(cnt_next);
        end
    end

    // Output beat.
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, out_count_reg, out_number_reg};
    assign m_tuser  = out_status_reg;

    // The memory never sees a read and a write at the same edge.
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_en && wr_en))
        else $error("bitmap read and write collide");

    // The free counter never exceeds the bitmap size.
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_ENTRIES))
        else $error("free counter out of range");

    // A result beat appears only out of the write-back step.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_FINISH))
        else $error("result raised outside write-back");

    // The remainder unit reports only while a free request waits for it.
    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIVIDE))
        else $error("remainder done outside divide state");

endmodule
`default_nettype wire

// ===== hdl/bffa_rem_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bffa_rem_unit
// Bit-serial restoring remainder unit: dividend mod divisor, one quotient
// bit per cycle. The divisor must be nonzero.
// ----------------------------------------------------------------------------
module bffa_rem_unit
    import bffa_pkg::*;
#(
    parameter int DIVISOR_W = 14
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [NUMBER_W-1:0]  dividend,
    input  wire logic [DIVISOR_W-1:0] divisor,
    output logic                      done,
    output logic [DIVISOR_W-1:0]      remainder
);

    localparam int STEP_W = $clog2(NUMBER_W);

    logic                 busy_reg;
    logic                 done_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [NUMBER_W-1:0]  shift_reg;
    logic [DIVISOR_W-1:0] divisor_reg;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIVISOR_W:0]   trial;
    logic [DIVISOR_W-1:0] rem_next;

    // One restoring step: bring in the next dividend bit, subtract if it fits.
    always_comb
    begin
        trial = {rem_reg, shift_reg[NUMBER_W-1]};
        if (trial >= {1'b0, divisor_reg})
        begin
            rem_next = DIVISOR_W'(trial - {1'b0, divisor_reg});
        end
        else
        begin
            rem_next = trial[DIVISOR_W-1:0];
        end
    end

    // Control: count the steps and flag the last one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(NUMBER_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg   <= dividend;
            divisor_reg <= divisor;
            rem_reg     <= '0;
        end
        else if (busy_reg)
        begin
            shift_reg <= {shift_reg[NUMBER_W-2:0], 1'b0};
            rem_reg   <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire

// ===== verif/tb_bitmap_first_free_allocator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bitmap_first_free_allocator
// Self-checking bench for the first-fit bitmap allocator. Requests go in on
// the slave stream, and a local copy of the bitmap, the free counter and the
// two registers predicts every result beat. Each result beat is compared
// field by field with the oldest prediction. Named tests cover directed
// corner cases, output back-pressure, randomized phases under many register
// settings, and a run that walks the free counter down on a single entry.
// ----------------------------------------------------------------------------
module tb_bitmap_first_free_allocator;
    import bffa_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 10;
    localparam int IDLE_SETTLE    = 8;
    localparam int END_SETTLE     = 300;
    localparam int PRESSURE_HOLD  = 1500;
    localparam int PHASE_ITEMS    = 140;
    localparam int FLOOR_PAIRS    = 50;
    localparam int MAX_REPORTS    = 10;
    localparam int CYCLE_LIMIT    = 6000000;

    // One result beat as seen on the master stream.
    typedef struct packed {
        logic [NUMBER_W-1:0] number;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
    } alloc_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [0:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [STATUS_W-1:0]   m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic                  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Local copy of the allocator state and registers.
    bit [DEF_MAX_ENTRIES-1:0] in_use_bits;
    int unsigned              free_left;
    logic [ENTRIES_W-1:0]     entries_cfg;
    logic [GROUP_W-1:0]       group_cfg;

    alloc_result_t pending_results [$];
    alloc_result_t wanted_result;
    alloc_result_t seen_result;

    int          error_count;
    int unsigned send_gap;
    int unsigned ready_wait;
    int unsigned hold_off_cycles;
    int unsigned cycle_count;
    bit          no_gaps;

    bitmap_first_free_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock.
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Idle cycles before the next beat on either side.
    function automatic int unsigned draw_gap();
        int unsigned gap;
        gap = no_gaps ? 0 : $urandom_range(0, 9);
        return gap;
    endfunction

    // Entry count actually searched: zero acts as one, large values clamp.
    function automatic int unsigned effective_span();
        int unsigned span;
        span = entries_cfg;
        if (span == 0)
        begin
            span = 1;
        end
        if (span > DEF_MAX_ENTRIES)
        begin
            span = DEF_MAX_ENTRIES;
        end
        return span;
    endfunction

    // Apply one request to the local state and return the result it causes.
    function automatic alloc_result_t predict_request(input logic op,
                                                      input logic [NUMBER_W-1:0] num);
        alloc_result_t       res;
        int unsigned         span;
        int unsigned         slot;
        logic [NUMBER_W-1:0] wrapped;
        span = effective_span();
        res.number = '0;
        if (op == OP_ALLOC)
        begin
            slot = 0;
            while (slot < span && in_use_bits[slot])
            begin
                slot++;
            end
            if (slot < span)
            begin
                in_use_bits[slot] = 1'b1;
                if (free_left > 0)
                begin
                    free_left--;
                end
                res.number = NUMBER_W'(slot + 32'd1 + 32'(group_cfg) * span);
                res.status = STAT_ALLOCATED;
            end
            else
            begin
                res.status = STAT_NONE_FREE;
            end
        end
        else
        begin
            // Entry number zero wraps to all ones before the modulo.
            wrapped = num - 32'd1;
            slot = wrapped % span;
            in_use_bits[slot] = 1'b0;
            if (free_left < span)
            begin
                free_left++;
            end
            res.status = STAT_FREED;
        end
        res.count = COUNT_W'(free_left);
        return res;
    endfunction

    // Entry number for a free: mostly one the allocator could have handed out.
    function automatic logic [NUMBER_W-1:0] pick_free_number();
        logic [NUMBER_W-1:0] num;
        int unsigned         span;
        int unsigned         slot;
        span = effective_span();
        case ($urandom_range(0, 9))
            0: num = '0;
            1: num = '1;
            2, 3: num = $urandom();
            default:
            begin
                if (span > 64 && $urandom_range(0, 3) != 0)
                begin
                    slot = $urandom_range(0, 63);
                end
                else
                begin
                    slot = $urandom_range(0, span - 1);
                end
                num = NUMBER_W'(slot + 32'd1 + 32'(group_cfg) * span
                                + span * $urandom_range(0, 3));
            end
        endcase
        return num;
    endfunction

    task automatic report_mismatch(input string what, input alloc_result_t want,
                                   input alloc_result_t got);
        error_count++;
        if (error_count <= MAX_REPORTS)
        begin
            $display("%0t mismatch (%s): expected number=%0d status=%0d count=%0d,",
                     $time, what, want.number, want.status, want.count);
            $display("    got number=%0d status=%0d count=%0d",
                     got.number, got.status, got.count);
        end
    endtask

    // Send one request beat and record the result it should cause.
    task automatic send_request(input logic op, input logic [NUMBER_W-1:0] num);
        repeat (send_gap) @(posedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= num;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        pending_results.insert(pending_results.size(), predict_request(op, num));
        // Valid stays high when the next beat follows at once.
        send_gap = draw_gap();
        if (send_gap != 0)
        begin
            s_tvalid <= 1'b0;
        end
    endtask

    task automatic write_register(input logic idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        if (idx == CFG_ENTRIES)
        begin
            entries_cfg = value[ENTRIES_W-1:0];
        end
        else
        begin
            group_cfg = value[GROUP_W-1:0];
        end
        cfg_valid <= 1'b0;
    endtask

    // Stop offering requests and wait until every result has come back.
    task automatic wait_idle();
        if (send_gap == 0)
        begin
            s_tvalid <= 1'b0;
        end
        send_gap = 0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (IDLE_SETTLE) @(posedge clk);
    endtask

    // Reset register values, wrap of entry number zero, holes, clamped counts.
    task automatic test_directed();
        send_request(OP_ALLOC, 32'd0);
        send_request(OP_ALLOC, 32'hFFFF_FFFF);
        send_request(OP_ALLOC, 32'd0);
        send_request(OP_FREE, 32'd2);
        send_request(OP_ALLOC, 32'd0);
        send_request(OP_FREE, 32'd0);
        send_request(OP_FREE, 32'hFFFF_FFFF);
        send_request(OP_FREE, 32'd8192);
        wait_idle();
        // Entry count zero behaves as a single entry.
        write_register(CFG_ENTRIES, 16'd0);
        write_register(CFG_GROUP, 16'hFFFF);
        send_request(OP_ALLOC, 32'd0);
        send_request(OP_FREE, 32'd1);
        send_request(OP_ALLOC, 32'd0);
        send_request(OP_ALLOC, 32'd0);
        wait_idle();
        // An oversized count clamps to the bitmap size.
        write_register(CFG_ENTRIES, 16'hFFFF);
        send_request(OP_ALLOC, 32'd0);
        wait_idle();
        write_register(CFG_ENTRIES, 16'd3);
        write_register(CFG_GROUP, 16'd7);
        send_request(OP_ALLOC, 32'd0);
        send_request(OP_ALLOC, 32'd0);
        send_request(OP_ALLOC, 32'd0);
        send_request(OP_FREE, 32'h8000_0000);
        send_request(OP_ALLOC, 32'd0);
        wait_idle();
    endtask

    // Hold the result side off so the block fills and stalls its input.
    task automatic test_result_backpressure();
        int unsigned n;
        write_register(CFG_ENTRIES, 16'd16);
        write_register(CFG_GROUP, 16'd3);
        no_gaps = 1'b1;
        hold_off_cycles = PRESSURE_HOLD;
        for (n = 0; n < 24; n++)
        begin
            if (n % 3 == 2)
            begin
                send_request(OP_FREE, pick_free_number());
            end
            else
            begin
                send_request(OP_ALLOC, $urandom());
            end
        end
        wait_idle();
        no_gaps = 1'b0;
    endtask

    // Random request mixes under a sweep of register settings.
    task automatic test_random_phases();
        logic [CFG_DATA_W-1:0] entry_settings [12];
        int unsigned           phase;
        int unsigned           n;
        int unsigned           alloc_pct;
        entry_settings = '{16'd5, 16'd1, 16'd0, 16'd32, 16'd33, 16'd8192,
                           16'd64, 16'hFFFF, 16'd100, 16'd8191, 16'd12, 16'd2};
        for (phase = 0; phase < 12; phase++)
        begin
            no_gaps = (phase % 3 == 2);
            write_register(CFG_ENTRIES, entry_settings[phase]);
            if (phase % 3 == 0)
            begin
                write_register(CFG_GROUP, 16'd0);
            end
            else if (phase % 3 == 1)
            begin
                write_register(CFG_GROUP, 16'hFFFF);
            end
            else
            begin
                write_register(CFG_GROUP, 16'($urandom()));
            end
            alloc_pct = $urandom_range(30, 75);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 99) < alloc_pct)
                begin
                    send_request(OP_ALLOC, $urandom());
                end
                else
                begin
                    send_request(OP_FREE, pick_free_number());
                end
            end
            wait_idle();
        end
        no_gaps = 1'b0;
    endtask

    // Allocate/free pairs on one entry walk the counter down, since a free at
    // or above the entry count leaves the counter alone.
    task automatic test_counter_floor();
        int unsigned pairs;
        no_gaps = 1'b1;
        write_register(CFG_ENTRIES, 16'd1);
        write_register(CFG_GROUP, 16'd9);
        send_request(OP_FREE, $urandom());
        pairs = 0;
        while (free_left > 1 && pairs < FLOOR_PAIRS)
        begin
            send_request(OP_ALLOC, $urandom());
            send_request(OP_FREE, $urandom());
            pairs++;
        end
        send_request(OP_ALLOC, $urandom());
        wait_idle();
        // Two entries: fill both, free one twice, free the other, refill.
        write_register(CFG_ENTRIES, 16'd2);
        send_request(OP_ALLOC, $urandom());
        send_request(OP_ALLOC, $urandom());
        send_request(OP_FREE, 32'd20);
        send_request(OP_FREE, 32'd20);
        send_request(OP_FREE, 32'd19);
        send_request(OP_ALLOC, $urandom());
        wait_idle();
        no_gaps = 1'b0;
    endtask

    // Result side: random stalls per beat plus the long hold-off.
    initial
    begin
        m_tready = 1'b0;
        ready_wait = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                ready_wait = draw_gap();
            end
            if (hold_off_cycles > 0)
            begin
                hold_off_cycles--;
                m_tready <= 1'b0;
            end
            else if (ready_wait > 0)
            begin
                ready_wait--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Compare each result beat with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            seen_result.number = m_tdata[NUMBER_W-1:0];
            seen_result.status = m_tuser;
            seen_result.count  = m_tdata[NUMBER_W +: COUNT_W];
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected beat", '0, seen_result);
            end
            else
            begin
                wanted_result = pending_results.pop_front();
                if (seen_result.number !== wanted_result.number)
                begin
                    report_mismatch("allocated_number", wanted_result, seen_result);
                end
                if (seen_result.status !== wanted_result.status)
                begin
                    report_mismatch("status", wanted_result, seen_result);
                end
                if (seen_result.count !== wanted_result.count)
                begin
                    report_mismatch("free_count", wanted_result, seen_result);
                end
            end
        end
    end

    // Watchdog.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("FAIL");
        $finish;
    end

    // Test sequence.
    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = 1'b0;
        cfg_data    = '0;
        error_count = 0;
        send_gap    = 0;
        no_gaps     = 1'b0;
        hold_off_cycles = 0;
        in_use_bits = '0;
        free_left   = DEF_MAX_ENTRIES;
        entries_cfg = ENTRIES_W'(8192);
        group_cfg   = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_result_backpressure();
        test_random_phases();
        test_counter_floor();

        wait_idle();
        repeat (END_SETTLE) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/bffa_pkg.sv
hdl/bffa_rem_unit.sv
hdl/bitmap_first_free_allocator.sv
verif/tb_bitmap_first_free_allocator.sv
